// File: rtl/assert_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SARD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define SARD_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SARD_ASSERT(label, clk, rst, prop, msg)
`define SARD_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/sard_pkg.sv
// Types and constants of the sync/async ratio dispatcher.
package sard_pkg;

  localparam int PAYLOAD_W = 16;
  localparam int RATIO_W   = 6;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 6'd4;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPT   = 2'd0;
  localparam logic [1:0] KIND_REJECT   = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  // Where a pending result takes its tag from
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_SYNC  = 2'd1;
  localparam logic [1:0] SRC_ASYNC = 2'd2;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic                 is_dispatch;
    logic [PAYLOAD_W-1:0] tag;
    logic                 is_async;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] tag;
    logic                 is_async;
    logic                 last;
  } result_t;

endpackage

// File: rtl/sard_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sard_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sard_front.sv
// Front end: accepts input requests, classifies them and queues commands.
module sard_front #(
  parameter int TAG_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode,
  input  logic [sard_pkg::PAYLOAD_W-1:0] request_tag,
  input  logic                           is_async,
  output logic                           cmd_valid,
  output sard_pkg::cmd_t                 cmd,
  input  logic                           cmd_take
);

  localparam int AW = $clog2(sard_pkg::CMD_DEPTH);
  localparam int CW = $clog2(sard_pkg::CMD_DEPTH + 1);
  localparam logic [sard_pkg::PAYLOAD_W-1:0] TAG_MASK =
    (TAG_BITS >= sard_pkg::PAYLOAD_W) ? {sard_pkg::PAYLOAD_W{1'b1}} :
    sard_pkg::PAYLOAD_W'((64'd1 << TAG_BITS) - 64'd1);

  sard_pkg::cmd_t entries [sard_pkg::CMD_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           accept;
  sard_pkg::cmd_t new_cmd;

  assign full      = (count == CW'(sard_pkg::CMD_DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  // Classify the incoming request
  always_comb begin
    new_cmd.is_dispatch = mode;
    new_cmd.tag         = request_tag & TAG_MASK;
    new_cmd.is_async    = is_async;
  end

  // Command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= new_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == AW'(sard_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == AW'(sard_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(accept) - CW'(cmd_take);
    end
  end

endmodule

// File: rtl/sard_back.sv
// Back end: executes add and dispatch commands against the two tag queues.
`include "assert_macros.svh"

module sard_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int STORE_W     = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  sard_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  input  logic [sard_pkg::RATIO_W-1:0] ratio,
  input  logic                         room,
  output logic                         res_valid,
  output sard_pkg::result_t            res
);

  localparam int HW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = $clog2(2 * QUEUE_DEPTH);
  localparam int RW   = sard_pkg::RATIO_W;
  localparam logic [CW-1:0]   FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [HW-1:0]   LAST_IDX = HW'(QUEUE_DEPTH - 1);
  localparam logic [SUMW-1:0] WRAP     = SUMW'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SYNC  = 2'd1;
  localparam logic [1:0] ST_ASYNC = 2'd2;

  logic [1:0]    state, state_next;
  logic [RW-1:0] iter, iter_next;
  logic          emitted, emitted_next;
  logic [HW-1:0] sync_head, sync_head_next, async_head, async_head_next;
  logic [CW-1:0] sync_count, sync_count_next, async_count, async_count_next;

  logic              pend_valid;
  sard_pkg::result_t pend_res;
  logic [1:0]        pend_src;

  logic              issue;
  sard_pkg::result_t iss_res;
  logic [1:0]        iss_src;

  logic               sync_we, async_we, sync_re, async_re;
  logic [STORE_W-1:0] wdata, sync_rdata, async_rdata;
  logic [SUMW-1:0]    sync_sum, async_sum;
  logic [HW-1:0]      sync_tail, async_tail;
  logic [RW:0]        iter_inc;
  logic               sync_last;

  // Tail positions of both queues
  assign sync_sum   = SUMW'(sync_head) + SUMW'(sync_count);
  assign async_sum  = SUMW'(async_head) + SUMW'(async_count);
  assign sync_tail  = (sync_sum >= WRAP) ? HW'(sync_sum - WRAP) : HW'(sync_sum);
  assign async_tail = (async_sum >= WRAP) ? HW'(async_sum - WRAP) : HW'(async_sum);
  assign wdata      = cmd.tag[STORE_W-1:0];

  // Final result of a dispatch when the sync batch ends and no async tag waits
  assign iter_inc  = {1'b0, iter} + 1'b1;
  assign sync_last = ((iter_inc == {1'b0, ratio}) || (sync_count == CW'(1)))
                     && (async_count == '0);

  // Sequencer
  always_comb begin
    state_next       = state;
    iter_next        = iter;
    emitted_next     = emitted;
    sync_head_next   = sync_head;
    async_head_next  = async_head;
    sync_count_next  = sync_count;
    async_count_next = async_count;
    cmd_take         = 1'b0;
    issue            = 1'b0;
    iss_src          = sard_pkg::SRC_NONE;
    iss_res.kind     = sard_pkg::KIND_IDLE;
    iss_res.tag      = '0;
    iss_res.is_async = 1'b0;
    iss_res.last     = 1'b1;
    sync_we          = 1'b0;
    async_we         = 1'b0;
    sync_re          = 1'b0;
    async_re         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && room) begin
          cmd_take = 1'b1;
          if (cmd.is_dispatch) begin
            state_next   = ST_SYNC;
            iter_next    = '0;
            emitted_next = 1'b0;
          end else begin
            issue            = 1'b1;
            iss_res.tag      = cmd.tag;
            iss_res.is_async = cmd.is_async;
            iss_res.kind     = sard_pkg::KIND_ACCEPT;
            if (cmd.is_async) begin
              if (async_count == FULL_CNT) begin
                iss_res.kind = sard_pkg::KIND_REJECT;
              end else begin
                async_we         = 1'b1;
                async_count_next = async_count + 1'b1;
              end
            end else begin
              if (sync_count == FULL_CNT) begin
                iss_res.kind = sard_pkg::KIND_REJECT;
              end else begin
                sync_we         = 1'b1;
                sync_count_next = sync_count + 1'b1;
              end
            end
          end
        end
      end
      ST_SYNC: begin
        if ((iter < ratio) && (sync_count != '0)) begin
          if (room) begin
            sync_re         = 1'b1;
            sync_head_next  = (sync_head == LAST_IDX) ? '0 : sync_head + 1'b1;
            sync_count_next = sync_count - 1'b1;
            iter_next       = iter_inc[RW-1:0];
            emitted_next    = 1'b1;
            issue           = 1'b1;
            iss_src         = sard_pkg::SRC_SYNC;
            iss_res.kind    = sard_pkg::KIND_DISPATCH;
            iss_res.last    = sync_last;
            if (sync_last) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          state_next = ST_ASYNC;
        end
      end
      ST_ASYNC: begin
        if (room) begin
          state_next = ST_IDLE;
          if (async_count != '0) begin
            async_re         = 1'b1;
            async_head_next  = (async_head == LAST_IDX) ? '0 : async_head + 1'b1;
            async_count_next = async_count - 1'b1;
            issue            = 1'b1;
            iss_src          = sard_pkg::SRC_ASYNC;
            iss_res.kind     = sard_pkg::KIND_DISPATCH;
            iss_res.is_async = 1'b1;
          end else if (!emitted) begin
            issue = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      iter        <= '0;
      emitted     <= 1'b0;
      sync_head   <= '0;
      async_head  <= '0;
      sync_count  <= '0;
      async_count <= '0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      iter        <= iter_next;
      emitted     <= emitted_next;
      sync_head   <= sync_head_next;
      async_head  <= async_head_next;
      sync_count  <= sync_count_next;
      async_count <= async_count_next;
      pend_valid  <= issue;
    end
  end

  // Pending result, registered in step with the RAM read data
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_res <= iss_res;
      pend_src <= iss_src;
    end
  end

  // Tag stores
  sard_ram #(.WIDTH(STORE_W), .DEPTH(QUEUE_DEPTH)) u_sync_ram (
    .clk  (clk),
    .we   (sync_we),
    .waddr(sync_tail),
    .wdata(wdata),
    .re   (sync_re),
    .raddr(sync_head),
    .rdata(sync_rdata)
  );

  sard_ram #(.WIDTH(STORE_W), .DEPTH(QUEUE_DEPTH)) u_async_ram (
    .clk  (clk),
    .we   (async_we),
    .waddr(async_tail),
    .wdata(wdata),
    .re   (async_re),
    .raddr(async_head),
    .rdata(async_rdata)
  );

  // Result toward the output queue
  assign res_valid = pend_valid;
  always_comb begin
    res = pend_res;
    unique case (pend_src)
      sard_pkg::SRC_SYNC:  res.tag = sard_pkg::PAYLOAD_W'(sync_rdata);
      sard_pkg::SRC_ASYNC: res.tag = sard_pkg::PAYLOAD_W'(async_rdata);
      default:             res.tag = pend_res.tag;
    endcase
  end

  `SARD_ASSERT(a_sync_bound, clk, rst, sync_count <= FULL_CNT, "sync count overflow")
  `SARD_ASSERT(a_async_pop_nonempty, clk, rst, async_re |-> (async_count != '0), "async pop while empty")
  `SARD_ASSERT(a_sync_pop_counts, clk, rst, sync_re |=> (sync_count == $past(sync_count) - 1'b1), "sync pop did not decrement count")
  `SARD_NEVER(a_wr_rd_same_cycle, clk, rst, (sync_we || async_we) && (sync_re || async_re), "store write and read in one cycle")

endmodule

// File: rtl/sard_out_fifo.sv
// Result queue between the back end and the output ports.
`include "assert_macros.svh"

module sard_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sard_pkg::result_t din,
  input  logic              pop,
  output logic              empty,
  output sard_pkg::result_t dout,
  output logic              room
);

  localparam int AW = $clog2(sard_pkg::OUT_DEPTH);
  localparam int CW = $clog2(sard_pkg::OUT_DEPTH + 1);

  sard_pkg::result_t entries [sard_pkg::OUT_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = entries[rd_ptr];
  // Two free slots: one for a result in flight, one for a new request
  assign room   = (count <= CW'(sard_pkg::OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(sard_pkg::OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(sard_pkg::OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

  `SARD_NEVER(a_no_overflow, clk, rst, push && (count == CW'(sard_pkg::OUT_DEPTH)), "result queue overflow")

endmodule

// File: rtl/sync_async_ratio_dispatcher.sv
// Top level: two-class weighted round-robin dispatcher of request tags.
// An add result passes the command queue, the back end's pending register and the result queue in that order.
// Adds sustain one request per cycle while the result queue has room.
// Dispatch: the take, then sync pops up to the ratio, then the async step;
//   it ends at the last sync tag when no async tag waits. A full result queue stalls it.
// Reset (rst, synchronous): both queues empty, ratio register back to 4.
module sync_async_ratio_dispatcher #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode,
  input  logic [sard_pkg::PAYLOAD_W-1:0] request_tag,
  input  logic                           is_async,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     kind,
  output logic [sard_pkg::PAYLOAD_W-1:0] out_tag,
  output logic                           out_async,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [sard_pkg::RATIO_W-1:0]   cfg_data
);

  localparam int STORE_W = (TAG_BITS < sard_pkg::PAYLOAD_W) ? TAG_BITS : sard_pkg::PAYLOAD_W;

  logic [sard_pkg::RATIO_W-1:0] sync_batch_ratio;
  logic                         cmd_valid;
  sard_pkg::cmd_t               cmd;
  logic                         cmd_take;
  logic                         room;
  logic                         res_valid;
  sard_pkg::result_t            res;
  sard_pkg::result_t            head_res;

  // Ratio register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_batch_ratio <= sard_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      sync_batch_ratio <= cfg_data;
    end
  end

  sard_front #(.TAG_BITS(TAG_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .request_tag(request_tag),
    .is_async   (is_async),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  sard_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .STORE_W(STORE_W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .ratio    (sync_batch_ratio),
    .room     (room),
    .res_valid(res_valid),
    .res      (res)
  );

  sard_out_fifo u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .din  (res),
    .pop  (pop),
    .empty(empty),
    .dout (head_res),
    .room (room)
  );

  assign kind      = head_res.kind;
  assign out_tag   = head_res.tag;
  assign out_async = head_res.is_async;
  assign last      = head_res.last;

endmodule

// File: test/testbench.sv
// Testbench for the sync/async ratio dispatcher: queued stimulus, self-checking monitor.
`timescale 1ns / 100ps

module testbench;

  localparam int TAGS_PER_CLASS = 32;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 55;

  typedef enum logic [2:0] {
    OP_ITEM,
    OP_CONFIG,
    OP_SETTLE,
    OP_PACE,
    OP_HOLDOFF
  } step_op_t;

  typedef struct {
    step_op_t                       op;
    logic                           dispatch;
    logic [sard_pkg::PAYLOAD_W-1:0] tag;
    logic                           cls;
    int                             arg_a;
    int                             arg_b;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           mode = 1'b0;
  logic [sard_pkg::PAYLOAD_W-1:0] request_tag = '0;
  logic                           is_async = 1'b0;
  logic                           pop = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [sard_pkg::RATIO_W-1:0]   cfg_data = '0;
  logic                           full;
  logic                           empty;
  logic [1:0]                     kind;
  logic [sard_pkg::PAYLOAD_W-1:0] out_tag;
  logic                           out_async;
  logic                           last;

  // Scheduler shadow state
  logic [sard_pkg::PAYLOAD_W-1:0] sync_tags[$];
  logic [sard_pkg::PAYLOAD_W-1:0] async_tags[$];
  logic [sard_pkg::RATIO_W-1:0]   batch_ratio = sard_pkg::RATIO_RESET;

  step_t             request_q[$];
  sard_pkg::result_t answer_q[$];
  step_t             cur_req;
  int                send_pct = 0;
  int                recv_pct = 0;
  int                quiet = 0;
  int                hold_left = 0;
  logic              hold_go = 1'b0;
  int                misses = 0;

  sync_async_ratio_dispatcher dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .request_tag (request_tag),
    .is_async    (is_async),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .out_tag     (out_tag),
    .out_async   (out_async),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the results one accepted request causes
  task automatic sched_request(input step_t r);
    sard_pkg::result_t res;
    int                n_sync;
    int                n_total;
    logic              ok;
    if (!r.dispatch) begin
      if (r.cls) begin
        ok = async_tags.size() < TAGS_PER_CLASS;
        if (ok) async_tags.push_back(r.tag);
      end else begin
        ok = sync_tags.size() < TAGS_PER_CLASS;
        if (ok) sync_tags.push_back(r.tag);
      end
      res.kind     = ok ? sard_pkg::KIND_ACCEPT : sard_pkg::KIND_REJECT;
      res.tag      = r.tag;
      res.is_async = r.cls;
      res.last     = 1'b1;
      answer_q.push_back(res);
    end else begin
      n_sync  = (sync_tags.size() < int'(batch_ratio)) ? sync_tags.size() : int'(batch_ratio);
      n_total = n_sync + ((async_tags.size() != 0) ? 1 : 0);
      for (int k = 0; k < n_sync; k++) begin
        res.kind     = sard_pkg::KIND_DISPATCH;
        res.tag      = sync_tags.pop_front();
        res.is_async = 1'b0;
        res.last     = (k == n_total - 1);
        answer_q.push_back(res);
      end
      if (async_tags.size() != 0) begin
        res.kind     = sard_pkg::KIND_DISPATCH;
        res.tag      = async_tags.pop_front();
        res.is_async = 1'b1;
        res.last     = 1'b1;
        answer_q.push_back(res);
      end
      // nothing popped: single idle result
      if (n_total == 0) begin
        res.kind     = sard_pkg::KIND_IDLE;
        res.tag      = '0;
        res.is_async = 1'b0;
        res.last     = 1'b1;
        answer_q.push_back(res);
      end
    end
  endtask

  task automatic log_miss(input string what, input sard_pkg::result_t want,
                          input sard_pkg::result_t got);
    misses++;
    if (misses <= 10)
      $display("%0t %s: want kind=%0d tag=%h async=%0b last=%0b",
               $realtime, what, want.kind, want.tag, want.is_async, want.last,
               " / got kind=%0d tag=%h async=%0b last=%0b",
               got.kind, got.tag, got.is_async, got.last);
  endtask

  // Driver: offers requests and handles control steps from the stimulus queue
  always @(posedge clk) begin
    logic held;
    logic push_nxt;
    logic we_nxt;
    logic hold_nxt;
    if (!rst) begin
      held = push && full;
      if (push && !full) sched_request(cur_req);
      if (cfg_we) batch_ratio = cfg_data;
      if (answer_q.size() == 0 && !push) quiet++;
      else quiet = 0;
      push_nxt = held;
      we_nxt   = 1'b0;
      hold_nxt = 1'b0;
      if (!held && !cfg_we && request_q.size() > 0) begin
        case (request_q[0].op)
          OP_ITEM: begin
            if ($urandom_range(99) >= send_pct) begin
              cur_req = request_q.pop_front();
              push_nxt = 1'b1;
              mode <= cur_req.dispatch;
              request_tag <= cur_req.tag;
              is_async <= cur_req.cls;
            end
          end
          OP_CONFIG: begin
            if (quiet >= SETTLE_CYCLES) begin
              we_nxt = 1'b1;
              cfg_data <= sard_pkg::RATIO_W'(request_q[0].arg_a);
              request_q.delete(0);
            end
          end
          OP_SETTLE: begin
            if (quiet >= SETTLE_CYCLES) request_q.delete(0);
          end
          OP_PACE: begin
            send_pct = request_q[0].arg_a;
            recv_pct <= request_q[0].arg_b;
            request_q.delete(0);
          end
          OP_HOLDOFF: begin
            hold_nxt = 1'b1;
            request_q.delete(0);
          end
          default: request_q.delete(0);
        endcase
      end
      push <= push_nxt;
      cfg_we <= we_nxt;
      hold_go <= hold_nxt;
    end
  end

  // Monitor: pops results and checks them against the predicted order
  always @(posedge clk) begin
    sard_pkg::result_t got;
    sard_pkg::result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        got = {kind, out_tag, out_async, last};
        if (answer_q.size() == 0) begin
          want = '0;
          log_miss("unexpected result", want, got);
        end else begin
          want = answer_q.pop_front();
          if (got.kind !== want.kind || got.tag !== want.tag ||
              got.is_async !== want.is_async || got.last !== want.last)
            log_miss("mismatch", want, got);
        end
      end
      // long receiver hold-off, counted here
      if (hold_go) hold_left = HOLD_CYCLES;
      else if (hold_left > 0) hold_left--;
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
    end
  end

  function automatic logic [sard_pkg::PAYLOAD_W-1:0] rand_tag();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return sard_pkg::PAYLOAD_W'($urandom);
    endcase
  endfunction

  task automatic queue_step(input step_op_t op, input logic dsp,
                            input logic [sard_pkg::PAYLOAD_W-1:0] tag,
                            input logic cls, input int a, input int b);
    step_t s;
    s.op = op;
    s.dispatch = dsp;
    s.tag = tag;
    s.cls = cls;
    s.arg_a = a;
    s.arg_b = b;
    request_q.push_back(s);
  endtask

  task automatic add_req(input logic cls, input logic [sard_pkg::PAYLOAD_W-1:0] tag);
    queue_step(OP_ITEM, 1'b0, tag, cls, 0, 0);
  endtask

  task automatic dispatch_req();
    queue_step(OP_ITEM, 1'b1, rand_tag(), 1'($urandom), 0, 0);
  endtask

  task automatic set_ratio(input int r);
    queue_step(OP_CONFIG, 1'b0, '0, 1'b0, r, 0);
  endtask

  task automatic set_pace(input int s, input int r);
    queue_step(OP_PACE, 1'b0, '0, 1'b0, s, r);
  endtask

  // Random bursts: runs of adds to one class, runs of dispatches, and mixed noise
  task automatic queue_random(input int count);
    int left;
    int len;
    int pick;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(9);
      if (pick < 4) len = $urandom_range(1, 12);
      else len = $urandom_range(1, 4);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if (pick < 4) add_req(pick[0], rand_tag());
        else if (pick < 7) dispatch_req();
        else queue_step(OP_ITEM, 1'($urandom), rand_tag(), 1'($urandom), 0, 0);
      end
      left -= len;
    end
  endtask

  // Stimulus plan and end of run
  initial begin
    int ph_send[6];
    int ph_recv[6];
    int ph_ratio[6];
    ph_send  = '{0, 88, 0, 25, 0, 88};
    ph_recv  = '{0, 0, 88, 25, 0, 88};
    ph_ratio = '{2, 63, 0, int'($urandom_range(3, 62)), 1, 4};

    // directed: ratio at its reset value first
    set_pace(0, 0);
    dispatch_req();                 // both queues empty
    add_req(1'b0, 16'h0000);
    add_req(1'b0, 16'hFFFF);
    add_req(1'b1, 16'hFFFF);
    add_req(1'b1, 16'h0000);
    add_req(1'b0, 16'h8001);
    dispatch_req();                 // sync runs dry, async still follows
    dispatch_req();                 // async only
    dispatch_req();                 // idle again
    set_ratio(0);
    add_req(1'b0, 16'h1234);
    dispatch_req();                 // zero ratio, only sync queued: pops nothing
    add_req(1'b1, 16'h5A5A);
    dispatch_req();
    set_ratio(63);
    add_req(1'b0, 16'h7FFF);
    add_req(1'b0, 16'h0001);
    add_req(1'b1, 16'hA5A5);
    dispatch_req();
    dispatch_req();

    // pressure: receiver holds off while both queues overfill
    queue_step(OP_HOLDOFF, 1'b0, '0, 1'b0, 0, 0);
    for (int k = 0; k < 36; k++) add_req(1'b0, rand_tag());
    for (int k = 0; k < 36; k++) add_req(1'b1, rand_tag());
    queue_step(OP_SETTLE, 1'b0, '0, 1'b0, 0, 0);
    dispatch_req();                 // drains the whole sync queue
    dispatch_req();
    dispatch_req();

    // random phases with different pacing and ratios
    for (int p = 0; p < 6; p++) begin
      set_pace(ph_send[p], ph_recv[p]);
      set_ratio(ph_ratio[p]);
      queue_random(PHASE_ITEMS);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // sample between edges so the driver's updates have settled
    while (request_q.size() > 0 || push || answer_q.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (misses == 0 && answer_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
